/* sv/sldb_pkg.sv */
package sldb_pkg;

    localparam int AMPLITUDE_BITS_DEF = 16;
    localparam int LOG_FRAC_BITS_DEF  = 16;

    localparam int GAIN_STEP_W = 12;
    localparam int OFFSET_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int RESULT_W    = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int PROD_W      = GAIN_STEP_W + GAIN_W;

    localparam logic [GAIN_STEP_W-1:0] GAIN_STEP_RESET    = 12'd579;
    localparam logic [OFFSET_W-1:0]    LEVEL_OFFSET_RESET = 16'd5563;

    localparam logic REG_GAIN_STEP    = 1'b0;
    localparam logic REG_LEVEL_OFFSET = 1'b1;

    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_RATIO = 1'b1;

    // 20*256/log2(10) in Q8 per log2 unit: 78125 * 2^13 / 415241.
    localparam int DB_MUL_W   = 17;
    localparam int DB_DIV_W   = 19;
    localparam int DB_SHIFT   = 13;
    localparam logic [DB_MUL_W-1:0] DB_MUL = 17'd78125;
    localparam logic [DB_DIV_W-1:0] DB_DIV = 19'd415241;
    localparam int DB_Q_BOUND = 1542;

    localparam int HALF_POWER_Q8 = 771;
    localparam int SAT_HIGH      = 127;
    localparam int SAT_LOW       = -128;

    typedef struct packed {
        logic              cmd;
        logic [GAIN_W-1:0] gain;
    } side_t;

endpackage

/* sv/sldb_divpipe.sv */
module sldb_divpipe #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] out_side
);

    logic          v_in    [QW];
    logic [NW-1:0] rem_in  [QW];
    logic [DW-1:0] div_in  [QW];
    logic [QW-1:0] quo_in  [QW];
    logic [SW-1:0] side_in [QW];

    logic          v_reg    [QW];
    logic [NW-1:0] rem_reg  [QW-1];
    logic [DW-1:0] div_reg  [QW-1];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    assign v_in[0]    = in_valid;
    assign rem_in[0]  = dividend;
    assign div_in[0]  = divisor;
    assign quo_in[0]  = '0;
    assign side_in[0] = in_side;

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            localparam int B = QW - 1 - i;
            logic [NW+DW-1:0] trial;
            logic             hit;
            logic [NW-1:0]    rem_next;

            assign trial    = {{NW{1'b0}}, div_in[i]} << B;
            assign hit      = {{DW{1'b0}}, rem_in[i]} >= trial;
            assign rem_next = hit ? rem_in[i] - trial[NW-1:0] : rem_in[i];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i] <= v_in[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i]  <= {quo_in[i][QW-2:0], hit};
                    side_reg[i] <= side_in[i];
                end
            end

            if (i < QW - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i] <= rem_next;
                        div_reg[i] <= div_in[i];
                    end
                end

                assign v_in[i+1]    = v_reg[i];
                assign rem_in[i+1]  = rem_reg[i];
                assign div_in[i+1]  = div_reg[i];
                assign quo_in[i+1]  = quo_reg[i];
                assign side_in[i+1] = side_reg[i];
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign quotient  = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

/* sv/sldb_log.sv */
module sldb_log #(
    parameter int AW = 16,
    parameter int FW = 16,
    parameter int SW = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [AW-1:0]             x,
    input  logic [SW-1:0]             in_side,
    output logic                      out_valid,
    output logic [$clog2(AW)+FW-1:0]  mag,
    output logic                      neg,
    output logic [SW-1:0]             out_side
);

    localparam int PW = $clog2(AW);
    localparam int MW = PW + FW;

    localparam logic [FW-1:0] QUARTER      = FW'(1) << (FW - 2);
    localparam logic [FW-1:0] FIVE_EIGHTHS = FW'(5) << (FW - 3);
    localparam logic [FW-1:0] SEG2_OFS     = FW'(5) << (FW - 6);
    localparam logic [FW-1:0] SEG3_OFS     = FW'(7) << (FW - 5);
    localparam logic [MW-1:0] ZERO_MAG     = MW'(21) << (FW - 4);

    logic [PW-1:0] p1;

    logic          v1_reg;
    logic [AW-1:0] x1_reg;
    logic [PW-1:0] p1_reg;
    logic          z1_reg;
    logic [SW-1:0] side1_reg;

    logic [AW+FW-1:0] norm;

    logic          v2_reg;
    logic [FW-1:0] m2_reg;
    logic [PW-1:0] p2_reg;
    logic          z2_reg;
    logic [SW-1:0] side2_reg;

    logic [FW+4:0] m21;
    logic [FW+4:0] m25;
    logic [FW-1:0] f3;

    logic          v3_reg;
    logic [MW-1:0] mag3_reg;
    logic          neg3_reg;
    logic [SW-1:0] side3_reg;

    always_comb
    begin
        p1 = '0;
        for (int j = 0; j < AW; j++)
        begin
            if (x[j])
            begin
                p1 = PW'(j);
            end
        end
    end

    assign norm = {x1_reg, {FW{1'b0}}} >> p1_reg;

    assign m21 = (FW+5)'(m2_reg) * (FW+5)'(21);
    assign m25 = (FW+5)'(m2_reg) * (FW+5)'(25);

    always_comb
    begin
        if (m2_reg < QUARTER)
        begin
            f3 = FW'(m21 >> 4);
        end
        else if (m2_reg < FIVE_EIGHTHS)
        begin
            f3 = m2_reg + SEG2_OFS;
        end
        else
        begin
            f3 = FW'(m25 >> 5) + SEG3_OFS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x;
            p1_reg    <= p1;
            z1_reg    <= (x == '0);
            side1_reg <= in_side;

            m2_reg    <= norm[FW-1:0];
            p2_reg    <= p1_reg;
            z2_reg    <= z1_reg;
            side2_reg <= side1_reg;

            mag3_reg  <= z2_reg ? ZERO_MAG : {p2_reg, f3};
            neg3_reg  <= z2_reg;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign mag       = mag3_reg;
    assign neg       = neg3_reg;
    assign out_side  = side3_reg;

endmodule

/* sv/sldb_scale.sv */
module sldb_scale
    import sldb_pkg::*;
#(
    parameter int MW = 20,
    parameter int FW = 16,
    parameter int QW = 15,
    parameter int SW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [MW-1:0] mag,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] q,
    output logic [SW-1:0] out_side
);

    localparam int XW  = MW + DB_MUL_W;
    localparam int LSH = (FW < DB_SHIFT) ? DB_SHIFT - FW : 0;
    localparam int RSH = (FW > DB_SHIFT) ? FW - DB_SHIFT : 0;
    localparam int ZW  = DB_DIV_W + QW;
    localparam int RW  = QW + 1;
    localparam int EW  = ZW + RW;
    localparam logic [RW-1:0] DB_RECIP = RW'((64'd1 << ZW) / DB_DIV);

    logic          v_reg;
    logic [XW-1:0] prod_reg;
    logic [SW-1:0] side_reg;

    logic          v2_reg;
    logic [ZW-1:0] z2_reg;
    logic [EW-1:0] est2_reg;
    logic [SW-1:0] side2_reg;

    logic          v3_reg;
    logic [ZW-1:0] z3_reg;
    logic [QW-1:0] qe3_reg;
    logic [ZW-1:0] back3_reg;
    logic [SW-1:0] side3_reg;

    logic          v4_reg;
    logic [QW-1:0] q4_reg;
    logic [SW-1:0] side4_reg;

    logic [XW+LSH-1:0] widened;
    logic [XW+LSH-1:0] shifted;
    logic [ZW-1:0]     z;
    logic [QW-1:0]     qe;
    logic [ZW-1:0]     rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= in_valid;
            v2_reg <= v_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign widened = (XW+LSH)'(prod_reg) << LSH;
    assign shifted = widened >> RSH;
    assign z       = ZW'(shifted);

    // The reciprocal estimate of the quotient is never high and at most one
    // low, so a single compare and subtract completes the division.
    assign qe  = QW'(est2_reg[EW-1:ZW]);
    assign rem = z3_reg - back3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= XW'(mag) * XW'(DB_MUL);
            side_reg  <= in_side;

            z2_reg    <= z;
            est2_reg  <= EW'(z) * EW'(DB_RECIP);
            side2_reg <= side_reg;

            z3_reg    <= z2_reg;
            qe3_reg   <= qe;
            back3_reg <= ZW'(qe) * ZW'(DB_DIV);
            side3_reg <= side2_reg;

            q4_reg    <= (rem >= ZW'(DB_DIV)) ? qe3_reg + QW'(1) : qe3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign q         = q4_reg;
    assign out_side  = side4_reg;

endmodule

/* sv/signal_level_db_meter.sv */
// Signal level and signal-to-noise meter giving a result in whole dB.
// Items arrive on the s_axis channel: tuser carries the command (level or
// ratio) and tdata carries the signal amplitude, gain code and noise amplitude.
// Each accepted transfer yields exactly one transfer on m_axis: tdata holds the
// result in two's complement dB and tuser flags a saturated result.
// The two calibration registers (gain step and level offset) sit on the APB
// port at byte addresses 0 and 4 and must be written only while the meter is
// idle; the block itself does not enforce this.
// The datapath is a pipeline: a restoring divider one quotient bit per stage
// (AMPLITUDE_BITS stages), three log2 stages, four scaling stages (a multiplier,
// a reciprocal multiplication, a back multiplication and a final correction),
// three stages that add the offsets and saturate, and the output register.
// One transfer per cycle is sustained while the receiver keeps m_axis_tready
// high.
// Reset clears all valid flags and loads the registers with their defaults.
// When the receiver stalls, the pending result is held stable and one more
// result is kept in a skid stage; the pipeline then freezes and s_axis_tready
// falls until the skid stage drains.
module signal_level_db_meter
    import sldb_pkg::*;
#(
    parameter int AMPLITUDE_BITS = AMPLITUDE_BITS_DEF,
    parameter int LOG_FRAC_BITS  = LOG_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // signal_amplitude, gain_code, noise_amplitude, zero padding
    input  logic [((2*AMPLITUDE_BITS+GAIN_W+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_db
    output logic [RESULT_W-1:0]    m_axis_tdata,
    // clamped
    output logic                   m_axis_tuser,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int AW = AMPLITUDE_BITS;
    localparam int FW = LOG_FRAC_BITS;
    localparam int MW = $clog2(AW) + FW;
    localparam int QW = $clog2(AW * DB_Q_BOUND);
    localparam int SW = $bits(side_t);
    localparam int TW = ((QW > PROD_W) ? QW : PROD_W) + 3;

    logic [GAIN_STEP_W-1:0] gain_step_reg;
    logic [OFFSET_W-1:0]    level_offset_reg;

    logic          en;
    logic [AW-1:0] sig;
    logic [AW-1:0] noise;
    logic [AW-1:0] divisor;
    side_t         in_side;

    logic          q1_valid;
    logic [AW-1:0] quot1;
    logic [SW-1:0] side1;

    logic          lg_valid;
    logic [MW-1:0] lg_mag;
    logic          lg_neg;
    logic [SW-1:0] side2;

    logic          sc_valid;
    logic [QW-1:0] sc_q;
    logic [SW:0]   sc_side;
    side_t         sc_info;
    logic          sc_neg;

    logic                  f1_v_reg;
    logic signed [QW:0]    f1_qs_reg;
    logic [PROD_W-1:0]     f1_prod_reg;
    logic                  f1_cmd_reg;

    logic                  f2_v_reg;
    logic signed [TW-1:0]  f2_total_reg;
    logic signed [TW-1:0]  total_next;

    logic                  f3_v_reg;
    logic [RESULT_W-1:0]   f3_res_reg;
    logic                  f3_clamp_reg;
    logic [TW-1:0]         abs_total;
    logic [TW-1:0]         abs_whole;
    logic signed [TW-1:0]  whole;
    logic [RESULT_W-1:0]   res_next;
    logic                  clamp_next;

    logic                  out_valid_reg;
    logic [RESULT_W-1:0]   out_data_reg;
    logic                  out_clamp_reg;
    logic                  skid_valid_reg;
    logic [RESULT_W-1:0]   skid_data_reg;
    logic                  skid_clamp_reg;
    logic                  incoming;
    logic                  take;

    logic                  cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_step_reg    <= GAIN_STEP_RESET;
            level_offset_reg <= LEVEL_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_GAIN_STEP:    gain_step_reg    <= pwdata[GAIN_STEP_W-1:0];
                REG_LEVEL_OFFSET: level_offset_reg <= pwdata[OFFSET_W-1:0];
                default:          gain_step_reg    <= gain_step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_GAIN_STEP:    prdata = APB_DATA_W'(gain_step_reg);
            REG_LEVEL_OFFSET: prdata = APB_DATA_W'($signed(level_offset_reg));
            default:          prdata = '0;
        endcase
    end

    // Input unpacking. A level request divides by one so that every item takes
    // the same path.
    assign en      = !skid_valid_reg;
    assign s_axis_tready = en;

    assign sig          = s_axis_tdata[AW-1:0];
    assign in_side.gain = s_axis_tdata[AW+GAIN_W-1:AW];
    assign noise        = s_axis_tdata[2*AW+GAIN_W-1:AW+GAIN_W];
    assign in_side.cmd  = s_axis_tuser;
    assign divisor      = ((s_axis_tuser == CMD_LEVEL) || (noise == '0)) ?
                          AW'(1) : noise;

    sldb_divpipe #(
        .NW (AW),
        .DW (AW),
        .QW (AW),
        .SW (SW)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .dividend  (sig),
        .divisor   (divisor),
        .in_side   (in_side),
        .out_valid (q1_valid),
        .quotient  (quot1),
        .out_side  (side1)
    );

    sldb_log #(
        .AW (AW),
        .FW (FW),
        .SW (SW)
    ) u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q1_valid),
        .x         (quot1),
        .in_side   (side1),
        .out_valid (lg_valid),
        .mag       (lg_mag),
        .neg       (lg_neg),
        .out_side  (side2)
    );

    sldb_scale #(
        .MW (MW),
        .FW (FW),
        .QW (QW),
        .SW (SW + 1)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lg_valid),
        .mag       (lg_mag),
        .in_side   ({lg_neg, side2}),
        .out_valid (sc_valid),
        .q         (sc_q),
        .out_side  (sc_side)
    );

    assign sc_neg  = sc_side[SW];
    assign sc_info = side_t'(sc_side[SW-1:0]);

    // Final stages: apply sign, offsets, truncation toward zero and saturation.
    always_comb
    begin
        if (f1_cmd_reg == CMD_LEVEL)
        begin
            total_next = TW'(f1_qs_reg) + TW'($signed(level_offset_reg))
                       - $signed(TW'(f1_prod_reg));
        end
        else
        begin
            total_next = TW'(f1_qs_reg) - TW'(HALF_POWER_Q8);
        end
    end

    assign abs_total = f2_total_reg[TW-1] ? TW'(-f2_total_reg) : TW'(f2_total_reg);
    assign abs_whole = abs_total >> 8;
    assign whole     = f2_total_reg[TW-1] ? -$signed(abs_whole) : $signed(abs_whole);

    always_comb
    begin
        if (whole > TW'(SAT_HIGH))
        begin
            res_next   = RESULT_W'(SAT_HIGH);
            clamp_next = 1'b1;
        end
        else if (whole < TW'(SAT_LOW))
        begin
            res_next   = RESULT_W'(SAT_LOW);
            clamp_next = 1'b1;
        end
        else
        begin
            res_next   = whole[RESULT_W-1:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= sc_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_qs_reg    <= sc_neg ? -$signed({1'b0, sc_q}) : $signed({1'b0, sc_q});
            f1_prod_reg  <= PROD_W'(gain_step_reg) * PROD_W'(sc_info.gain);
            f1_cmd_reg   <= sc_info.cmd;
            f2_total_reg <= total_next;
            f3_res_reg   <= res_next;
            f3_clamp_reg <= clamp_next;
        end
    end

    // Output register with a skid stage behind it.
    assign incoming = en && f3_v_reg;
    assign take     = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg  <= skid_data_reg;
                out_clamp_reg <= skid_clamp_reg;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg  <= f3_res_reg;
                skid_clamp_reg <= f3_clamp_reg;
            end
            else
            begin
                out_data_reg  <= f3_res_reg;
                out_clamp_reg <= f3_clamp_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clamp_reg;

endmodule

/* verif/signal_level_db_checker.sv */
// Scoreboard for the level and ratio meter. It predicts each reading from the
// accepted input transfer and the register values seen on the APB port.
module signal_level_db_checker
    import sldb_pkg::*;
#(
    parameter int S_DATA_W = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    input  logic                  s_axis_tuser,

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [RESULT_W-1:0]   m_axis_tdata,
    input  logic                  m_axis_tuser,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,

    output int                    pending,
    output int                    errors
);

    localparam int AMP_W  = AMPLITUDE_BITS_DEF;
    localparam int FRAC_W = LOG_FRAC_BITS_DEF;
    localparam longint unsigned DB_SCALE_NUM = 64'd5120000000;
    localparam longint unsigned DB_SCALE_DEN = 64'd3321928;

    typedef struct packed {
        logic                cmd;
        logic [RESULT_W-1:0] db;
        logic                clamped;
    } reading_t;

    reading_t                   readings_due[$];
    logic [GAIN_STEP_W-1:0]     gain_step_q8;
    logic signed [OFFSET_W-1:0] level_offset_q8;
    int                         err_count = 0;
    int                         due_count = 0;

    assign pending = due_count;
    assign errors  = err_count;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        err_count++;
    endtask

    // Piecewise linear log2 with FRAC_W fraction bits.
    function automatic longint log2_fit(input longint unsigned x);
        longint unsigned one_q;
        longint unsigned t;
        longint unsigned p;
        longint unsigned m;
        longint unsigned f;
        one_q = 64'd1 << FRAC_W;
        if (x == 0)
            return -longint'((64'd21 << FRAC_W) >> 4);
        p = 0;
        t = x;
        while (t > 1)
        begin
            t = t >> 1;
            p++;
        end
        m = ((x << FRAC_W) >> p) - one_q;
        if (m < (one_q >> 2))
            f = (21 * m) >> 4;
        else if (m < ((5 * one_q) >> 3))
            f = m + ((5 * one_q) >> 6);
        else
            f = ((25 * m) >> 5) + ((7 * one_q) >> 5);
        return longint'((p << FRAC_W) + f);
    endfunction

    // Twenty times log10 in Q8, with the magnitude truncated towards zero.
    function automatic longint db20_q8(input longint unsigned x);
        longint          l;
        longint unsigned mag;
        longint unsigned q;
        l = log2_fit(x);
        mag = (l < 0) ? -l : l;
        q = (mag * DB_SCALE_NUM) / (DB_SCALE_DEN << FRAC_W);
        return (l < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic reading_t predict_reading(input logic cmd,
                                                 input logic [AMP_W-1:0] sig,
                                                 input logic [GAIN_W-1:0] gain_c,
                                                 input logic [AMP_W-1:0] noise);
        longint           total;
        longint           whole;
        logic [AMP_W-1:0] divisor;
        reading_t         r;
        if (cmd == CMD_LEVEL)
        begin
            total = db20_q8(sig) + longint'(level_offset_q8)
                  - longint'(gain_step_q8) * longint'(gain_c);
        end
        else
        begin
            divisor = (noise == '0) ? AMP_W'(1) : noise;
            total = db20_q8(sig / divisor) - HALF_POWER_Q8;
        end
        whole = total / 256;
        r.cmd = cmd;
        r.clamped = 1'b0;
        if (whole > SAT_HIGH)
        begin
            whole = SAT_HIGH;
            r.clamped = 1'b1;
        end
        else if (whole < SAT_LOW)
        begin
            whole = SAT_LOW;
            r.clamped = 1'b1;
        end
        r.db = whole[RESULT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            gain_step_q8    = GAIN_STEP_RESET;
            level_offset_q8 = LEVEL_OFFSET_RESET;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_GAIN_STEP:    gain_step_q8    = pwdata[GAIN_STEP_W-1:0];
                        REG_LEVEL_OFFSET: level_offset_q8 = pwdata[OFFSET_W-1:0];
                        default: ;
                    endcase
                end
                else if (paddr[APB_ADDR_W-1:2] == REG_GAIN_STEP)
                begin
                    if (prdata[GAIN_STEP_W-1:0] !== gain_step_q8)
                        report_mismatch($sformatf("gain step read %0d, expected %0d",
                                                  prdata[GAIN_STEP_W-1:0], gain_step_q8));
                end
                else if (prdata[OFFSET_W-1:0] !== level_offset_q8)
                begin
                    report_mismatch($sformatf("level offset read %0d, expected %0d",
                                              $signed(prdata[OFFSET_W-1:0]), level_offset_q8));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                readings_due.push_back(predict_reading(
                    s_axis_tuser,
                    s_axis_tdata[AMP_W-1:0],
                    s_axis_tdata[AMP_W +: GAIN_W],
                    s_axis_tdata[AMP_W+GAIN_W +: AMP_W]));
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with no transfer waiting",
                                              $signed(m_axis_tdata)));
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (m_axis_tdata !== want.db)
                        report_mismatch($sformatf("%s result %0d dB, expected %0d dB",
                                                  want.cmd == CMD_LEVEL ? "level" : "ratio",
                                                  $signed(m_axis_tdata), $signed(want.db)));
                    if (m_axis_tuser !== want.clamped)
                        report_mismatch($sformatf("%s clamp flag %b, expected %b",
                                                  want.cmd == CMD_LEVEL ? "level" : "ratio",
                                                  m_axis_tuser, want.clamped));
                end
            end
            due_count = readings_due.size();
        end
    end

endmodule

/* verif/tb_signal_level_db_meter.sv */
module tb_signal_level_db_meter;
    import sldb_pkg::*;

    localparam int AMP_W          = AMPLITUDE_BITS_DEF;
    localparam int S_DATA_W       = ((2*AMP_W+GAIN_W+7)/8)*8;
    localparam int SETTLE_CYCLES  = 48;
    localparam int ITEMS_PER_STEP = 140;
    localparam int SETTING_COUNT  = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // signal_amplitude, gain_code, noise_amplitude
    logic [S_DATA_W-1:0]   s_axis_tdata;
    // command
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // result_db
    logic [RESULT_W-1:0]   m_axis_tdata;
    // clamped
    logic                  m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int errors;
    bit idling;
    int level_count;
    int ratio_count;
    int setting_count;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    signal_level_db_meter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    signal_level_db_checker #(
        .S_DATA_W (S_DATA_W)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pending       (pending),
        .errors        (errors)
    );

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [AMP_W-1:0] sig,
                             input logic [GAIN_W-1:0] gain_c, input logic [AMP_W-1:0] noise);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = S_DATA_W'({noise, gain_c, sig});
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        if (cmd == CMD_LEVEL)
            level_count++;
        else
            ratio_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic read_registers();
        apb_access(1'b0, {REG_GAIN_STEP, 2'b00}, '0);
        apb_access(1'b0, {REG_LEVEL_OFFSET, 2'b00}, '0);
    endtask

    function automatic logic [AMP_W-1:0] random_amp();
        return AMP_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
    endfunction

    initial
    begin
        logic [GAIN_STEP_W-1:0]     step_val;
        logic signed [OFFSET_W-1:0] offset_val;
        logic                       cmd;
        logic [AMP_W-1:0]           noise;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LEVEL;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idling        = 1'b1;
        level_count   = 0;
        ratio_count   = 0;
        setting_count = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        read_registers();

        // Zero amplitude, then each segment of the fit and its boundaries.
        send_item(CMD_LEVEL, 16'h0000, 8'h00, 16'hFFFF);
        send_item(CMD_LEVEL, 16'h0001, 8'h00, random_amp());
        send_item(CMD_LEVEL, 16'h0002, 8'hFF, random_amp());
        send_item(CMD_LEVEL, 16'h0003, 8'h01, random_amp());
        send_item(CMD_LEVEL, 16'h0009, 8'h80, random_amp());
        send_item(CMD_LEVEL, 16'h000A, 8'h7F, random_amp());
        send_item(CMD_LEVEL, 16'h000C, 8'h10, random_amp());
        send_item(CMD_LEVEL, 16'h000D, 8'h08, random_amp());
        send_item(CMD_LEVEL, 16'h8000, 8'h00, random_amp());
        send_item(CMD_LEVEL, 16'hFFFF, 8'h00, 16'h0000);
        send_item(CMD_LEVEL, 16'hFFFF, 8'hFF, random_amp());
        send_item(CMD_LEVEL, 16'h5555, 8'hAA, random_amp());
        send_item(CMD_LEVEL, 16'hAAAA, 8'h55, random_amp());
        // Ratio requests, including zero noise and a quotient of zero.
        send_item(CMD_RATIO, 16'h0000, 8'hFF, 16'h0000);
        send_item(CMD_RATIO, 16'hFFFF, 8'h00, 16'h0000);
        send_item(CMD_RATIO, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(CMD_RATIO, 16'h0001, 8'h00, 16'hFFFF);
        send_item(CMD_RATIO, 16'hFFFF, 8'h55, 16'h0001);
        send_item(CMD_RATIO, 16'hAAAA, 8'hAA, 16'h5555);
        send_item(CMD_RATIO, 16'h0064, 8'h00, 16'h0003);
        send_item(CMD_RATIO, 16'h15B3, 8'h00, 16'h0000);

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            case (s)
                0:
                begin
                    step_val   = '0;
                    offset_val = 16'sh8000;
                end
                1:
                begin
                    step_val   = '1;
                    offset_val = 16'sh7FFF;
                end
                2:
                begin
                    step_val   = '1;
                    offset_val = 16'sh8000;
                end
                3:
                begin
                    step_val   = '0;
                    offset_val = 16'sh7FFF;
                end
                SETTING_COUNT - 1:
                begin
                    step_val   = GAIN_STEP_RESET;
                    offset_val = LEVEL_OFFSET_RESET;
                end
                default:
                begin
                    step_val   = GAIN_STEP_W'($urandom_range(0, 4095));
                    offset_val = OFFSET_W'($urandom_range(0, 65535));
                end
            endcase

            drain();
            apb_access(1'b1, {REG_GAIN_STEP, 2'b00}, APB_DATA_W'(step_val));
            apb_access(1'b1, {REG_LEVEL_OFFSET, 2'b00}, APB_DATA_W'($unsigned(offset_val)));
            read_registers();
            setting_count++;

            for (int i = 0; i < ITEMS_PER_STEP; i++)
            begin
                if (s == SETTING_COUNT - 1)
                    idling = 1'b0;
                else if (i % 35 == 0)
                    idling = ($urandom_range(0, 3) != 0);
                cmd = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 2) == 0)
                    noise = random_amp();
                else
                    noise = AMP_W'($urandom_range(0, 15));
                send_item(cmd, random_amp(), GAIN_W'($urandom_range(0, 255)), noise);
            end
        end

        drain();
        $display("Covered %0d level and %0d ratio requests over %0d register settings,",
                 level_count, ratio_count, setting_count);
        $display("with random stalls on both channels and a final stretch at full rate.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out waiting for the meter to finish.");
        $display("Test completed with failures");
        $finish;
    end

endmodule
